### src/mfdt_pkg.sv
// ----------------------------------------------------------------------------
// MSAA fragment depth test package
// Shared payload types, per-pixel sample row, sequencer states and widths.
// ----------------------------------------------------------------------------
package mfdt_pkg;

  localparam int SAMPLES = 4;
  localparam int ZW      = 24;  // depth width
  localparam int CW      = 24;  // color width
  localparam int EW      = 38;  // edge value width (signed)
  localparam int NW      = 64;  // depth numerator width
  localparam int SW      = 40;  // edge sum width
  localparam int QW      = 24;  // divider quotient width

  localparam logic [3:0]    OFF_LO    = 4'd4;
  localparam logic [3:0]    OFF_MID   = 4'd8;
  localparam logic [3:0]    OFF_HI    = 4'd12;
  localparam logic [ZW-1:0] DEPTH_FAR = 24'hFFFFFF;

  typedef struct packed {
    logic               action;
    logic [15:0]        pixel_pos;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic [23:0]        vertex_a_depth;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic [23:0]        vertex_b_depth;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic [23:0]        vertex_c_depth;
    logic [23:0]        tri_color;
  } mfdt_in_t;

  typedef struct packed {
    logic [15:0] out_pixel_pos;
    logic [23:0] pixel_color;
    logic        pixel_written;
  } mfdt_out_t;

  // All four samples of one pixel, stored as one memory row.
  typedef struct packed {
    logic [SAMPLES-1:0][ZW-1:0] depth;
    logic [SAMPLES-1:0][CW-1:0] color;
  } mfdt_row_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_XY,
    ST_READ,
    ST_LOAD,
    ST_EDGE,
    ST_COVER,
    ST_NUM,
    ST_DIV,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_WRITE,
    ST_DONE
  } mfdt_state_e;

endpackage

### src/mfdt_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces QW quotient bits, one per cycle, for a numerator known to be less
// than the divisor shifted left by QW.
// ----------------------------------------------------------------------------
module mfdt_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [mfdt_pkg::NW-1:0] num_i,
  input  logic [mfdt_pkg::SW-1:0] den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [mfdt_pkg::QW-1:0] quot_o
);
  import mfdt_pkg::*;

  localparam int CNTW = $clog2(QW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [SW-1:0]   den_q, den_d;
  logic [QW-1:0]   low_q, low_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [SW+1:0]   trial;

  assign trial = {1'b0, rem_q, low_q[QW-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(QW - 1);
      rem_d  = num_i[NW-1:QW];
      low_d  = num_i[QW-1:0];
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      // A clear borrow bit means the shifted remainder reached the divisor.
      if (!trial[SW+1]) begin
        rem_d  = trial[SW-1:0];
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[SW-2:0], low_q[QW-1]};
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      low_d = {low_q[QW-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/mfdt_row_mem.sv
// ----------------------------------------------------------------------------
// Sample row memory
// One row per pixel holding four sample depths and colors; one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module mfdt_row_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  mfdt_pkg::mfdt_row_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output mfdt_pkg::mfdt_row_t rdata_o
);
  import mfdt_pkg::*;

  mfdt_row_t mem [DEPTH];
  mfdt_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/msaa_fragment_depth_test.sv
// ----------------------------------------------------------------------------
// MSAA fragment depth test
// Tests one pixel against a flat-shaded triangle at four subsamples (or the
// center), depth-tests each covered sample and returns the resolved color.
// ----------------------------------------------------------------------------
// After reset the block sweeps the sample memory, one pixel a cycle, through
// all SCREEN_WIDTH*SCREEN_HEIGHT rows (at most 65536) before it takes the first
// transaction; configuration writes are taken only while the block is idle.
// An off-screen transaction goes straight to its result and a clear writes a
// cleared row first. A shade transaction tests each of the four samples with
// MSAA on, or the center with it off, and passes each covered sample through
// the shared one-bit-per-cycle divider, which computes its interpolated depth.
// One transaction is in work at a time; a finished result waits in the output
// register and holds the sequencer only while the previous result there is
// still unaccepted.
module msaa_fragment_depth_test #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfdt_pkg::mfdt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfdt_pkg::mfdt_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_data_i
);
  import mfdt_pkg::*;

  localparam int unsigned PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned MEM_DEPTH = (PIXELS > 65536) ? 65536 : PIXELS;
  localparam int          AW        = $clog2(MEM_DEPTH);
  // Row of a 16-bit pixel index by reciprocal multiplication.
  localparam int unsigned XY_SHIFT  = 16 + $clog2(SCREEN_WIDTH);
  localparam logic [16:0] XY_RECIP  =
    17'(((64'd1 << XY_SHIFT) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  mfdt_state_e     state_q, state_d;
  mfdt_in_t        item_q, item_d;
  logic            msaa_q;
  logic [15:0]     x_q, x_d, y_q, y_d;
  logic [1:0]      k_q, k_d;
  logic [1:0]      sel_q, sel_d;
  logic signed [EW-1:0] e_q [3];
  logic signed [EW-1:0] e_d [3];
  logic [SW-1:0]   sum_q, sum_d;
  logic [NW-1:0]   num_q, num_d;
  mfdt_row_t       row_q, row_d;
  logic            written_q, written_d;
  logic            zero_q, zero_d;
  mfdt_out_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [AW-1:0]   init_q, init_d;

  mfdt_row_t       clear_row;
  mfdt_row_t       rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mfdt_row_t       mem_wdata;

  logic            div_start, div_busy, div_done;
  logic [NW-1:0]   div_num;
  logic [SW-1:0]   div_den;
  logic [QW-1:0]   div_quot;

  logic [32:0]     y_prod;
  logic [15:0]     y_calc, x_calc;

  // Edge unit signals
  logic [3:0]           off_x, off_y;
  logic signed [17:0]   px, py;
  logic signed [15:0]   ax, ay, bx, by;
  logic signed [16:0]   d_bx, d_by;
  logic signed [17:0]   d_px, d_py;
  logic signed [34:0]   p1, p2;
  logic signed [EW-1:0] e_val;
  logic                 covered;
  logic signed [EW-1:0] e_sum;
  logic [35:0]          m_e;
  logic [ZW-1:0]        m_z;
  logic [59:0]          m_prod;
  logic [ZW-1:0]        depth;
  logic [9:0]           acc_r, acc_g, acc_b;

  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      clear_row.depth[i] = DEPTH_FAR;
      clear_row.color[i] = '0;
    end
  end

  // The row is found in ST_XY and the column from it in ST_READ, which follows.
  assign y_prod = 33'(item_q.pixel_pos) * 33'(XY_RECIP);
  assign y_calc = 16'(y_prod >> XY_SHIFT);
  assign x_calc = item_q.pixel_pos - 16'(y_q * 16'(SCREEN_WIDTH));

  // Sample point in 1/16 pixel units.
  assign off_x = msaa_q ? (k_q[1] ? OFF_HI : OFF_LO) : OFF_MID;
  assign off_y = msaa_q ? (k_q[0] ? OFF_HI : OFF_LO) : OFF_MID;
  assign px    = $signed({2'b00, x_q[11:0], off_x});
  assign py    = $signed({2'b00, y_q[11:0], off_y});

  // Edges are taken in the order a-b, b-c, c-a.
  always_comb begin
    case (sel_q)
      2'd0: begin
        ax = item_q.vertex_a_x; ay = item_q.vertex_a_y;
        bx = item_q.vertex_b_x; by = item_q.vertex_b_y;
      end
      2'd1: begin
        ax = item_q.vertex_b_x; ay = item_q.vertex_b_y;
        bx = item_q.vertex_c_x; by = item_q.vertex_c_y;
      end
      default: begin
        ax = item_q.vertex_c_x; ay = item_q.vertex_c_y;
        bx = item_q.vertex_a_x; by = item_q.vertex_a_y;
      end
    endcase
  end

  assign d_bx  = 17'(bx) - 17'(ax);
  assign d_by  = 17'(by) - 17'(ay);
  assign d_px  = px - 18'(ax);
  assign d_py  = py - 18'(ay);
  assign p1    = d_bx * d_py;
  assign p2    = d_by * d_px;
  assign e_val = EW'(p1) - EW'(p2);

  always_comb begin
    covered = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (e_q[i][EW-1] || (e_q[i] == '0)) begin
        covered = 1'b0;
      end
    end
  end

  assign e_sum = e_q[0] + e_q[1] + e_q[2];

  // Each vertex depth is weighted by the edge opposite to it.
  always_comb begin
    case (sel_q)
      2'd0: begin
        m_e = e_q[1][35:0];
        m_z = item_q.vertex_a_depth;
      end
      2'd1: begin
        m_e = e_q[2][35:0];
        m_z = item_q.vertex_b_depth;
      end
      default: begin
        m_e = e_q[0][35:0];
        m_z = item_q.vertex_c_depth;
      end
    endcase
  end

  assign m_prod = m_e * m_z;
  assign depth  = div_quot;

  always_comb begin
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      acc_r = acc_r + 10'(row_q.color[i][23:16]);
      acc_g = acc_g + 10'(row_q.color[i][15:8]);
      acc_b = acc_b + 10'(row_q.color[i][7:0]);
    end
  end

  assign div_start = (state_q == ST_DIV);
  assign div_num   = num_q;
  assign div_den   = sum_q;

  mfdt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mem_we    = (state_q == ST_INIT) || (state_q == ST_WRITE);
  assign mem_waddr = (state_q == ST_INIT) ? init_q : item_q.pixel_pos[AW-1:0];
  assign mem_wdata = (state_q == ST_INIT) ? clear_row : row_q;

  mfdt_row_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (item_q.pixel_pos[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    sel_d       = sel_q;
    e_d         = e_q;
    sum_d       = sum_q;
    num_d       = num_q;
    row_d       = row_q;
    written_d   = written_q;
    zero_d      = zero_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    init_d      = init_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        init_d = init_q + 1'b1;
        if (init_q == AW'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d    = in_data_i;
          written_d = 1'b0;
          zero_d    = 1'b0;
          if (32'(in_data_i.pixel_pos) >= 32'(PIXELS)) begin
            zero_d  = 1'b1;
            state_d = ST_DONE;
          end else if (in_data_i.action) begin
            row_d   = clear_row;
            zero_d  = 1'b1;
            state_d = ST_WRITE;
          end else begin
            state_d = ST_XY;
          end
        end
      end
      ST_XY: begin
        y_d     = y_calc;
        state_d = ST_READ;
      end
      ST_READ: begin
        x_d     = x_calc;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        row_d   = rdata;
        k_d     = '0;
        sel_d   = '0;
        state_d = ST_EDGE;
      end
      ST_EDGE: begin
        e_d[sel_q] = e_val;
        if (sel_q == 2'd2) begin
          state_d = ST_COVER;
        end else begin
          sel_d = sel_q + 1'b1;
        end
      end
      ST_COVER: begin
        sel_d = '0;
        if (covered) begin
          sum_d   = SW'(e_sum);
          num_d   = '0;
          state_d = ST_NUM;
        end else if (msaa_q && (k_q != 2'd3)) begin
          k_d     = k_q + 1'b1;
          state_d = ST_EDGE;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_NUM: begin
        num_d = num_q + NW'(m_prod);
        if (sel_q == 2'd2) begin
          state_d = ST_DIV;
        end else begin
          sel_d = sel_q + 1'b1;
        end
      end
      ST_DIV: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        sel_d = '0;
        if (msaa_q) begin
          if (depth < row_q.depth[k_q]) begin
            row_d.depth[k_q] = depth;
            row_d.color[k_q] = item_q.tri_color;
            written_d        = 1'b1;
          end
        end else if (depth < row_q.depth[0]) begin
          // With one center sample the pass fills all four samples.
          for (int i = 0; i < SAMPLES; i++) begin
            row_d.depth[i] = depth;
            row_d.color[i] = item_q.tri_color;
          end
          written_d = 1'b1;
        end
        if (msaa_q && (k_q != 2'd3)) begin
          k_d     = k_q + 1'b1;
          state_d = ST_EDGE;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_pixel_pos = item_q.pixel_pos;
          out_d.pixel_written = written_q;
          out_d.pixel_color   = zero_q ? '0 :
                                {acc_r[9:2], acc_g[9:2], acc_b[9:2]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
      init_q      <= '0;
      msaa_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      init_q      <= init_d;
      if (cfg_valid_i && cfg_ready_o) begin
        msaa_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    x_q       <= x_d;
    y_q       <= y_d;
    k_q       <= k_d;
    sel_q     <= sel_d;
    e_q       <= e_d;
    sum_q     <= sum_d;
    num_q     <= num_d;
    row_q     <= row_d;
    written_q <= written_d;
    zero_q    <= zero_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The MSAA setting only changes between transactions.
  assign cfg_ready_o = (state_q == ST_IDLE);

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");

  // An accepted transaction blocks the input until its result is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // The memory is never written while the block waits for input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_IDLE) |-> !mem_we)
    else $error("memory write while idle");

endmodule
